/* hw/rtl/rsh_pkg.sv */
// Shared types and constants of the RGB sharpener with luma histogram.
`default_nettype none

package rsh_pkg;

   localparam int IMAGE_WIDTH_W  = 12;
   localparam int IMAGE_HEIGHT_W = 16;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 12'd640;
   localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 16'd480;

   localparam int CHAN_W    = 8;
   localparam int BIN_W     = 3;
   localparam int BIN_COUNT = 5;
   localparam int COUNT_W   = 28;

   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_AW    = 3;
   localparam int QUEUE_LW    = 4;

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  red_out;
      logic [CHAN_W-1:0]  green_out;
      logic [CHAN_W-1:0]  blue_out;
      logic [BIN_W-1:0]   luma_bin;
      logic [COUNT_W-1:0] bin0_total;
      logic [COUNT_W-1:0] bin1_total;
      logic [COUNT_W-1:0] bin2_total;
      logic [COUNT_W-1:0] bin3_total;
      logic [COUNT_W-1:0] bin4_total;
      logic               run_last;
      logic               frame_done;
   } rsp_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   localparam int PIXEL_W = $bits(pixel_type);

   typedef struct packed {
      pixel_type        center_px;
      logic [BIN_W-1:0] center_bin;
      pixel_type        own_px;
      logic [BIN_W-1:0] own_bin;
      logic             has_center;
      logic             has_own;
      logic             clear_counts;
      logic             frame_done;
   } entry_type;

endpackage

`default_nettype wire

/* hw/rtl/rsh_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module rsh_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/rsh_front.sv */
// Front end: raster position tracking, line stores, cross kernel and luma binning.
`default_nettype none

module rsh_front #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rsh_pkg::req_type                     req_payload,
   input  logic [rsh_pkg::IMAGE_WIDTH_W-1:0]    image_width,
   input  logic [rsh_pkg::IMAGE_HEIGHT_W-1:0]   image_height,
   input  logic [rsh_pkg::QUEUE_LW-1:0]         queue_level,
   output logic                                 queue_push,
   output rsh_pkg::entry_type                   queue_entry
);

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int CMPW  = (WW > rsh_pkg::IMAGE_WIDTH_W) ? WW : rsh_pkg::IMAGE_WIDTH_W;
   localparam int HW    = rsh_pkg::IMAGE_HEIGHT_W;
   localparam int OCC_W = rsh_pkg::QUEUE_LW + 1;
   localparam int BW    = rsh_pkg::BIN_W;

   localparam int LUMA_W      = 22;
   localparam int LUMA_R_COEF = 2126;
   localparam int LUMA_G_COEF = 7152;
   localparam int LUMA_B_COEF = 722;
   localparam int LUMA_SCALE  = 10000;
   localparam int LUMA_ROUND  = 5000;

   localparam logic [LUMA_W-1:0] BIN1_FLOOR = LUMA_W'(51 * LUMA_SCALE - LUMA_ROUND);
   localparam logic [LUMA_W-1:0] BIN2_FLOOR = LUMA_W'(102 * LUMA_SCALE - LUMA_ROUND);
   localparam logic [LUMA_W-1:0] BIN3_FLOOR = LUMA_W'(153 * LUMA_SCALE - LUMA_ROUND);
   localparam logic [LUMA_W-1:0] BIN4_FLOOR = LUMA_W'(204 * LUMA_SCALE - LUMA_ROUND);

   localparam logic signed [11:0] CENTER_GAIN = 12'sd5;
   localparam logic signed [11:0] PIX_MAX     = 12'sd255;

   typedef struct packed {
      logic has_center;
      logic border;
      logic has_own;
      logic frame_done;
      logic frame_start;
   } flags_type;

   function automatic logic [7:0] sharpen(input logic [7:0] c, input logic [7:0] u,
                                          input logic [7:0] d, input logic [7:0] l,
                                          input logic [7:0] r);
      logic signed [11:0] v;
      logic [7:0]         res;
      v = CENTER_GAIN * $signed({4'b0, c}) - $signed({4'b0, u}) - $signed({4'b0, d})
          - $signed({4'b0, l}) - $signed({4'b0, r});
      if (v < 12'sd0) begin
         res = 8'd0;
      end else if (v > PIX_MAX) begin
         res = 8'd255;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

   function automatic logic [LUMA_W-1:0] luma_sum(input rsh_pkg::pixel_type p);
      return LUMA_W'(LUMA_R_COEF) * LUMA_W'(p.red)
           + LUMA_W'(LUMA_G_COEF) * LUMA_W'(p.green)
           + LUMA_W'(LUMA_B_COEF) * LUMA_W'(p.blue);
   endfunction

   // Rounded luma below k is the same as the unrounded sum below k*10000-5000.
   function automatic logic [BW-1:0] bin_of(input logic [LUMA_W-1:0] s);
      logic [BW-1:0] b;
      if (s < BIN1_FLOOR) begin
         b = 3'd0;
      end else if (s < BIN2_FLOOR) begin
         b = 3'd1;
      end else if (s < BIN3_FLOOR) begin
         b = 3'd2;
      end else if (s < BIN4_FLOOR) begin
         b = 3'd3;
      end else begin
         b = 3'd4;
      end
      return b;
   endfunction

   logic [AW-1:0]       col_ff, col_in;
   logic [HW-1:0]       row_ff, row_in;
   logic [CMPW-1:0]     w_cfg;
   logic [WW-1:0]       w_eff, x_plus1;
   logic [HW-1:0]       h_eff, y_eff;
   logic [HW:0]         y_plus1;
   logic [AW-1:0]       x_eff;
   logic                accept, last_col, last_row;
   flags_type           flags;
   rsh_pkg::pixel_type  cur;

   logic                s1_valid_ff, s1_valid_in;
   flags_type           s1_flags_ff, s1_flags_in;
   rsh_pkg::pixel_type  s1_cur_ff, s1_cur_in;
   logic [AW-1:0]       s1_x_ff, s1_x_in;

   rsh_pkg::pixel_type  center_rd, right_rd, up_rd, sharp, center_px;
   rsh_pkg::pixel_type  left_ff, left_in;

   logic                s2_valid_ff, s2_valid_in;
   flags_type           s2_flags_ff, s2_flags_in;
   rsh_pkg::pixel_type  s2_center_ff, s2_center_in;
   rsh_pkg::pixel_type  s2_own_ff, s2_own_in;

   logic                s3_valid_ff, s3_valid_in;
   flags_type           s3_flags_ff, s3_flags_in;
   rsh_pkg::pixel_type  s3_center_ff, s3_center_in;
   rsh_pkg::pixel_type  s3_own_ff, s3_own_in;
   logic [LUMA_W-1:0]   s3_center_sum_ff, s3_center_sum_in;
   logic [LUMA_W-1:0]   s3_own_sum_ff, s3_own_sum_in;

   logic                clear_pending_ff, clear_pending_in;
   logic [OCC_W-1:0]    occupancy;

   always_comb begin
      occupancy = OCC_W'(queue_level) + OCC_W'(s1_valid_ff) + OCC_W'(s2_valid_ff)
                + OCC_W'(s3_valid_ff);
      req_stall = reset || (occupancy >= OCC_W'(rsh_pkg::QUEUE_DEPTH));
      accept    = req_valid && !req_stall;

      w_cfg = CMPW'(image_width);
      if (w_cfg == '0) begin
         w_eff = WW'(1);
      end else if (w_cfg > CMPW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(w_cfg);
      end
      h_eff = (image_height == '0) ? HW'(1) : image_height;

      x_eff    = (WW'(col_ff) >= w_eff) ? '0 : col_ff;
      y_eff    = (row_ff >= h_eff) ? '0 : row_ff;
      x_plus1  = WW'(x_eff) + WW'(1);
      y_plus1  = {1'b0, y_eff} + (HW + 1)'(1);
      last_col = (x_plus1 == w_eff);
      last_row = (y_plus1 == {1'b0, h_eff});

      flags.has_center  = (y_eff != '0);
      flags.border      = (x_eff == '0) || last_col || (y_eff == HW'(1));
      flags.has_own     = last_row;
      flags.frame_done  = last_row && last_col;
      flags.frame_start = (x_eff == '0) && (y_eff == '0);

      cur.red   = req_payload.red_in;
      cur.green = req_payload.green_in;
      cur.blue  = req_payload.blue_in;

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         col_in = last_col ? '0 : AW'(x_plus1);
         row_in = last_col ? (last_row ? '0 : y_plus1[HW-1:0]) : y_eff;
      end

      s1_valid_in = accept;
      s1_flags_in = flags;
      s1_cur_in   = cur;
      s1_x_in     = x_eff;
   end

   rsh_ram #(.WIDTH(rsh_pkg::PIXEL_W), .DEPTH(MAX_WIDTH)) u_prev_center (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (x_eff),
      .wr_data (cur),
      .rd_addr (x_eff),
      .rd_data (center_rd)
   );

   rsh_ram #(.WIDTH(rsh_pkg::PIXEL_W), .DEPTH(MAX_WIDTH)) u_prev_right (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (x_eff),
      .wr_data (cur),
      .rd_addr (x_eff + AW'(1)),
      .rd_data (right_rd)
   );

   rsh_ram #(.WIDTH(rsh_pkg::PIXEL_W), .DEPTH(MAX_WIDTH)) u_older (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_x_ff),
      .wr_data (center_rd),
      .rd_addr (x_eff),
      .rd_data (up_rd)
   );

   // The left neighbor is the center read by the request just before, in the same row.
   always_comb begin
      sharp.red   = sharpen(center_rd.red, up_rd.red, s1_cur_ff.red, left_ff.red,
                            right_rd.red);
      sharp.green = sharpen(center_rd.green, up_rd.green, s1_cur_ff.green, left_ff.green,
                            right_rd.green);
      sharp.blue  = sharpen(center_rd.blue, up_rd.blue, s1_cur_ff.blue, left_ff.blue,
                            right_rd.blue);
      center_px   = s1_flags_ff.border ? center_rd : sharp;
      left_in     = s1_valid_ff ? center_rd : left_ff;

      s2_valid_in  = s1_valid_ff;
      s2_flags_in  = s1_flags_ff;
      s2_center_in = center_px;
      s2_own_in    = s1_cur_ff;

      s3_valid_in      = s2_valid_ff;
      s3_flags_in      = s2_flags_ff;
      s3_center_in     = s2_center_ff;
      s3_own_in        = s2_own_ff;
      s3_center_sum_in = luma_sum(s2_center_ff);
      s3_own_sum_in    = luma_sum(s2_own_ff);

      queue_push = s3_valid_ff && (s3_flags_ff.has_center || s3_flags_ff.has_own);
      queue_entry.center_px    = s3_center_ff;
      queue_entry.center_bin   = bin_of(s3_center_sum_ff);
      queue_entry.own_px       = s3_own_ff;
      queue_entry.own_bin      = bin_of(s3_own_sum_ff);
      queue_entry.has_center   = s3_flags_ff.has_center;
      queue_entry.has_own      = s3_flags_ff.has_own;
      queue_entry.clear_counts = s3_flags_ff.frame_start || clear_pending_ff;
      queue_entry.frame_done   = s3_flags_ff.frame_done;

      // A frame start that yields no result hands its count clear to the next entry.
      clear_pending_in = clear_pending_ff;
      if (s3_valid_ff) begin
         clear_pending_in = queue_push ? 1'b0
                                       : (clear_pending_ff || s3_flags_ff.frame_start);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff           <= '0;
         row_ff           <= '0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         s3_valid_ff      <= 1'b0;
         clear_pending_ff <= 1'b0;
      end else begin
         col_ff           <= col_in;
         row_ff           <= row_in;
         s1_valid_ff      <= s1_valid_in;
         s2_valid_ff      <= s2_valid_in;
         s3_valid_ff      <= s3_valid_in;
         clear_pending_ff <= clear_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_flags_ff      <= s1_flags_in;
      s1_cur_ff        <= s1_cur_in;
      s1_x_ff          <= s1_x_in;
      left_ff          <= left_in;
      s2_flags_ff      <= s2_flags_in;
      s2_center_ff     <= s2_center_in;
      s2_own_ff        <= s2_own_in;
      s3_flags_ff      <= s3_flags_in;
      s3_center_ff     <= s3_center_in;
      s3_own_ff        <= s3_own_in;
      s3_center_sum_ff <= s3_center_sum_in;
      s3_own_sum_ff    <= s3_own_sum_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/rsh_fifo.sv */
// Short queue of classified pixel entries between the front and back ends.
`default_nettype none

module rsh_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  rsh_pkg::entry_type           push_entry,
   input  logic                         pop,
   output rsh_pkg::entry_type           head,
   output logic [rsh_pkg::QUEUE_LW-1:0] level,
   output logic                         empty
);

   localparam int QAW = rsh_pkg::QUEUE_AW;
   localparam int QLW = rsh_pkg::QUEUE_LW;

   rsh_pkg::entry_type entries_ff [rsh_pkg::QUEUE_DEPTH];
   logic [QAW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QLW-1:0]     level_ff, level_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QAW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      level_in  = level_ff + QLW'(push) - QLW'(pop);
      head      = entries_ff[rd_ptr_ff];
      level     = level_ff;
      empty     = (level_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/rsh_back.sv */
// Back end: splits entries into results, keeps the bin counts, drives the output register.
`default_nettype none

module rsh_back (
   input  logic               clock,
   input  logic               reset,
   input  rsh_pkg::entry_type head,
   input  logic               queue_empty,
   output logic               queue_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsh_pkg::rsp_type   rsp_payload
);

   localparam int CW = rsh_pkg::COUNT_W;
   localparam int BW = rsh_pkg::BIN_W;
   localparam int NB = rsh_pkg::BIN_COUNT;

   logic               load, use_center, last_result, clear_now;
   rsh_pkg::pixel_type px;
   logic [BW-1:0]      bin;
   logic [CW-1:0]      counts_ff [NB];
   logic [CW-1:0]      counts_in [NB];
   logic               phase_ff, phase_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsh_pkg::rsp_type   rsp_payload_ff, rsp_payload_in;

   always_comb begin
      load        = !queue_empty && (!rsp_valid_ff || !rsp_stall);
      use_center  = head.has_center && !phase_ff;
      px          = use_center ? head.center_px : head.own_px;
      bin         = use_center ? head.center_bin : head.own_bin;
      last_result = !use_center || !head.has_own;
      clear_now   = head.clear_counts && !phase_ff;

      for (int k = 0; k < NB; k++) begin
         counts_in[k] = counts_ff[k];
         if (load) begin
            counts_in[k] = (clear_now ? '0 : counts_ff[k]) + CW'(bin == BW'(k));
         end
      end

      queue_pop    = load && last_result;
      phase_in     = load ? !last_result : phase_ff;
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

      rsp_payload_in = rsp_payload_ff;
      if (load) begin
         rsp_payload_in.red_out    = px.red;
         rsp_payload_in.green_out  = px.green;
         rsp_payload_in.blue_out   = px.blue;
         rsp_payload_in.luma_bin   = bin;
         rsp_payload_in.bin0_total = counts_in[0];
         rsp_payload_in.bin1_total = counts_in[1];
         rsp_payload_in.bin2_total = counts_in[2];
         rsp_payload_in.bin3_total = counts_in[3];
         rsp_payload_in.bin4_total = counts_in[4];
         rsp_payload_in.run_last   = last_result;
         rsp_payload_in.frame_done = !use_center && head.frame_done;
      end

      rsp_valid   = rsp_valid_ff;
      rsp_payload = rsp_payload_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NB; k++) begin
            counts_ff[k] <= '0;
         end
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < NB; k++) begin
            counts_ff[k] <= counts_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/rgb_sharpen_with_luma_histogram_unit.sv */
// Top level of the RGB cross-kernel sharpener with running luma histogram.
//
// Pixels enter on the req_ channel in raster order, one per request, and results
// leave on the rsp_ channel; both use valid and stall. The user sets image width and
// height through the csr_ write port only while idle; the block does not enforce it.
// Each request in row y yields the pixel of row y-1 at the same column, sharpened
// unless on the border; a request in the last row yields its own pixel as a second
// result. Row 0 yields nothing unless the frame has a single row.
// Accepted requests pass the front-end registers, the queue and the output register.
// The front end takes one request per cycle, bounded by the eight-entry queue ahead
// of the output stage, which sends one result per cycle unless stalled,
// so in the last row, whose requests carry two results each, req_stall can rise.
// Reset clears the position counters, bin counts, queue and output register and sets
// the width to 640 and the height to 480; the line stores are not cleared. req_stall
// is high during reset. When the receiver stalls, the output result holds, the queue
// fills and then req_stall rises.
`default_nettype none

module rgb_sharpen_with_luma_histogram_unit #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  rsh_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output rsh_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_wr_en,
   input  logic [rsh_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rsh_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [rsh_pkg::IMAGE_WIDTH_W-1:0]  image_width_ff, image_width_in;
   logic [rsh_pkg::IMAGE_HEIGHT_W-1:0] image_height_ff, image_height_in;

   logic                         queue_push, queue_pop, queue_empty;
   rsh_pkg::entry_type           push_entry, head;
   logic [rsh_pkg::QUEUE_LW-1:0] queue_level;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            rsh_pkg::CSR_IMAGE_WIDTH: begin
               image_width_in = csr_wdata[rsh_pkg::IMAGE_WIDTH_W-1:0];
            end
            rsh_pkg::CSR_IMAGE_HEIGHT: begin
               image_height_in = csr_wdata[rsh_pkg::IMAGE_HEIGHT_W-1:0];
            end
            default: begin
               image_width_in = image_width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= rsh_pkg::IMAGE_WIDTH_RESET;
         image_height_ff <= rsh_pkg::IMAGE_HEIGHT_RESET;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
      end
   end

   rsh_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .queue_level  (queue_level),
      .queue_push   (queue_push),
      .queue_entry  (push_entry)
   );

   rsh_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .pop        (queue_pop),
      .head       (head),
      .level      (queue_level),
      .empty      (queue_empty)
   );

   rsh_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .queue_empty (queue_empty),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* hw/rtl/rsh_checker.sv */
// Port-level assertions for the sharpener top level and the bind that attaches them.
`default_nettype none

module rsh_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rsh_pkg::rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("Stalled result changed or was dropped.");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result shown right after reset.");

   a_reset_stall: assert property (@(posedge clock)
      reset |-> req_stall)
      else $error("Request channel open during reset.");

   a_bin_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.luma_bin == 3'd0 && rsp_payload.bin0_total != '0)
                 || (rsp_payload.luma_bin == 3'd1 && rsp_payload.bin1_total != '0)
                 || (rsp_payload.luma_bin == 3'd2 && rsp_payload.bin2_total != '0)
                 || (rsp_payload.luma_bin == 3'd3 && rsp_payload.bin3_total != '0)
                 || (rsp_payload.luma_bin == 3'd4 && rsp_payload.bin4_total != '0))
      else $error("Result bin is out of range or not counted.");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_done |-> rsp_payload.run_last)
      else $error("Frame end result is not the last one of its request.");

endmodule

bind rgb_sharpen_with_luma_histogram_unit rsh_checker u_rsh_checker (.*);

`default_nettype wire

/* bench/rgb_sharpen_checker.sv */
// Checker that predicts sharpened pixels and luma histogram totals and compares the results.
module rgb_sharpen_checker #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  rsh_pkg::req_type                req_payload,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  rsh_pkg::rsp_type                rsp_payload,
   input  logic                            csr_wr_en,
   input  logic [rsh_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rsh_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              pending_count,
   output int                              error_count,
   output int                              checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SHARPEN_GAIN = 5;
   localparam int CHAN_MAX     = 255;
   localparam int LUMA_EDGE_1  = 51;
   localparam int LUMA_EDGE_2  = 102;
   localparam int LUMA_EDGE_3  = 153;
   localparam int LUMA_EDGE_4  = 204;
   localparam int REPORT_LIMIT = 10;

   rsh_pkg::pixel_type                 older_line [MAX_WIDTH];
   rsh_pkg::pixel_type                 recent_line [MAX_WIDTH];
   int unsigned                        row_now;
   int unsigned                        col_now;
   logic [rsh_pkg::COUNT_W-1:0]        bin_tally [rsh_pkg::BIN_COUNT];
   logic [rsh_pkg::IMAGE_WIDTH_W-1:0]  width_reg;
   logic [rsh_pkg::IMAGE_HEIGHT_W-1:0] height_reg;
   rsh_pkg::rsp_type                   expected_pixels [$];
   int                                 failures = 0;
   int                                 compared = 0;

   function automatic logic [rsh_pkg::CHAN_W-1:0] sharpen(
         input logic [rsh_pkg::CHAN_W-1:0] c, u, d, l, r);
      int v;
      v = SHARPEN_GAIN * int'(c) - int'(u) - int'(d) - int'(l) - int'(r);
      if (v < 0) v = 0;
      if (v > CHAN_MAX) v = CHAN_MAX;
      return rsh_pkg::CHAN_W'(v);
   endfunction

   function automatic rsh_pkg::rsp_type tally_pixel(input rsh_pkg::pixel_type px);
      rsh_pkg::rsp_type          res;
      int                        luma;
      logic [rsh_pkg::BIN_W-1:0] bin;
      luma = (2126 * int'(px.red) + 7152 * int'(px.green) + 722 * int'(px.blue) + 5000)
             / 10000;
      if (luma < LUMA_EDGE_1) bin = 0;
      else if (luma < LUMA_EDGE_2) bin = 1;
      else if (luma < LUMA_EDGE_3) bin = 2;
      else if (luma < LUMA_EDGE_4) bin = 3;
      else bin = 4;
      bin_tally[bin] = bin_tally[bin] + 1'b1;
      res = '0;
      res.red_out = px.red;
      res.green_out = px.green;
      res.blue_out = px.blue;
      res.luma_bin = bin;
      res.bin0_total = bin_tally[0];
      res.bin1_total = bin_tally[1];
      res.bin2_total = bin_tally[2];
      res.bin3_total = bin_tally[3];
      res.bin4_total = bin_tally[4];
      return res;
   endfunction

   task automatic predict_pixel_results(input rsh_pkg::req_type rq);
      int unsigned        w, h, x, y;
      rsh_pkg::pixel_type cur, mid, up, lf, rt, shown;
      rsh_pkg::rsp_type   made [2];
      int                 n;
      n = 0;
      w = width_reg;
      h = height_reg;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h < 1) h = 1;
      if (col_now >= w) col_now = 0;
      if (row_now >= h) row_now = 0;
      x = col_now;
      y = row_now;
      if (x == 0 && y == 0) begin
         foreach (bin_tally[k]) bin_tally[k] = '0;
      end
      cur.red = rq.red_in;
      cur.green = rq.green_in;
      cur.blue = rq.blue_in;
      if (y > 0) begin
         mid = recent_line[x];
         shown = mid;
         if (!(x == 0 || x + 1 == w || y == 1)) begin
            up = older_line[x];
            lf = older_line[x - 1];
            rt = recent_line[x + 1];
            shown.red = sharpen(mid.red, up.red, cur.red, lf.red, rt.red);
            shown.green = sharpen(mid.green, up.green, cur.green, lf.green, rt.green);
            shown.blue = sharpen(mid.blue, up.blue, cur.blue, lf.blue, rt.blue);
         end
         made[n] = tally_pixel(shown);
         n++;
      end
      older_line[x] = recent_line[x];
      recent_line[x] = cur;
      if (y + 1 == h) begin
         made[n] = tally_pixel(cur);
         made[n].frame_done = (x + 1 == w);
         n++;
      end
      if (n > 0) made[n - 1].run_last = 1'b1;
      for (int i = 0; i < n; i++) expected_pixels.push_back(made[i]);
      if (x + 1 >= w) begin
         col_now = 0;
         row_now = (y + 1 >= h) ? 0 : y + 1;
      end else begin
         col_now = x + 1;
      end
   endtask

   function automatic string differing_fields(input rsh_pkg::rsp_type want,
                                              input rsh_pkg::rsp_type got);
      string s;
      s = "";
      if (want.red_out !== got.red_out) s = {s, " red_out"};
      if (want.green_out !== got.green_out) s = {s, " green_out"};
      if (want.blue_out !== got.blue_out) s = {s, " blue_out"};
      if (want.luma_bin !== got.luma_bin) s = {s, " luma_bin"};
      if (want.bin0_total !== got.bin0_total) s = {s, " bin0_total"};
      if (want.bin1_total !== got.bin1_total) s = {s, " bin1_total"};
      if (want.bin2_total !== got.bin2_total) s = {s, " bin2_total"};
      if (want.bin3_total !== got.bin3_total) s = {s, " bin3_total"};
      if (want.bin4_total !== got.bin4_total) s = {s, " bin4_total"};
      if (want.run_last !== got.run_last) s = {s, " run_last"};
      if (want.frame_done !== got.frame_done) s = {s, " frame_done"};
      return s;
   endfunction

   function automatic string describe(input rsh_pkg::rsp_type r);
      return $sformatf("rgb %0d,%0d,%0d bin %0d totals %0d/%0d/%0d/%0d/%0d last %0b done %0b",
                       r.red_out, r.green_out, r.blue_out, r.luma_bin, r.bin0_total,
                       r.bin1_total, r.bin2_total, r.bin3_total, r.bin4_total, r.run_last,
                       r.frame_done);
   endfunction

   always @(posedge clock) begin
      rsh_pkg::rsp_type want;
      string            diffs;
      if (reset) begin
         expected_pixels.delete();
         foreach (bin_tally[k]) bin_tally[k] = '0;
         row_now = 0;
         col_now = 0;
         width_reg = rsh_pkg::IMAGE_WIDTH_RESET;
         height_reg = rsh_pkg::IMAGE_HEIGHT_RESET;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == rsh_pkg::CSR_IMAGE_WIDTH)
               width_reg = csr_wdata[rsh_pkg::IMAGE_WIDTH_W-1:0];
            else if (csr_index == rsh_pkg::CSR_IMAGE_HEIGHT)
               height_reg = csr_wdata;
         end
         if (req_valid && !req_stall) predict_pixel_results(req_payload);
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("Unexpected result at %0t: %s", $realtime, describe(rsp_payload));
            end else begin
               want = expected_pixels.pop_front();
               compared++;
               diffs = differing_fields(want, rsp_payload);
               if (diffs != "") begin
                  failures++;
                  if (failures <= REPORT_LIMIT) begin
                     $display("Result %0d differs in%s at %0t", compared, diffs, $realtime);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(rsp_payload));
                  end
               end
            end
         end
      end
      pending_count <= expected_pixels.size();
      error_count <= failures;
      checked_count <= compared;
   end

endmodule

/* bench/rgb_sharpen_with_luma_histogram_unit_tb.sv */
// Top of the testbench: clock, reset, pixel stimulus, frame settings and the verdict.
module rgb_sharpen_with_luma_histogram_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WIDTH     = 2048;
   localparam int RANDOM_PIXELS = 1850;
   localparam int WIDE_PIXELS   = 64;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 500000;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   rsh_pkg::req_type                req_payload = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   rsh_pkg::rsp_type                rsp_payload;
   logic                            csr_wr_en = 1'b0;
   logic [rsh_pkg::CSR_INDEX_W-1:0] csr_index = rsh_pkg::CSR_IMAGE_WIDTH;
   logic [rsh_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   int   tx_idle_pct = 0;
   int   rx_idle_pct = 0;
   logic rsp_hold = 1'b0;
   logic hold_request = 1'b0;
   int   pending_count;
   int   error_count;
   int   checked_count;
   int   pixels_sent = 0;
   int   settings_used = 0;
   int   cycle_count = 0;

   rgb_sharpen_with_luma_histogram_unit #(.MAX_WIDTH(MAX_WIDTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   rgb_sharpen_checker #(.MAX_WIDTH(MAX_WIDTH)) checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .pending_count(pending_count),
      .error_count(error_count),
      .checked_count(checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= rsp_hold || ($urandom_range(0, 99) < rx_idle_pct);
   end

   // A long output hold-off lets the queue fill so that the request side stalls.
   initial begin
      wait (hold_request);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_count);
      $display("FAILURE");
      $finish;
   end

   function automatic rsh_pkg::req_type rgb(input int r, input int g, input int b);
      rsh_pkg::req_type px;
      px.red_in = rsh_pkg::CHAN_W'(r);
      px.green_in = rsh_pkg::CHAN_W'(g);
      px.blue_in = rsh_pkg::CHAN_W'(b);
      return px;
   endfunction

   function automatic logic [rsh_pkg::CHAN_W-1:0] pick_level(
         input bit smooth, input logic [rsh_pkg::CHAN_W-1:0] base);
      int unsigned roll;
      roll = $urandom_range(0, 3);
      if (smooth) return base + rsh_pkg::CHAN_W'($urandom_range(0, 25));
      if (roll == 0) return 8'h00;
      if (roll == 1) return 8'hff;
      return rsh_pkg::CHAN_W'($urandom_range(0, 255));
   endfunction

   task automatic drive_pixel(input rsh_pkg::req_type px);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= px;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame_size(input int unsigned w, input int unsigned h);
      quiesce();
      csr_wr_en <= 1'b1;
      csr_index <= rsh_pkg::CSR_IMAGE_WIDTH;
      csr_wdata <= rsh_pkg::CSR_DATA_W'(w);
      @(posedge clock);
      csr_index <= rsh_pkg::CSR_IMAGE_HEIGHT;
      csr_wdata <= rsh_pkg::CSR_DATA_W'(h);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   task automatic send_frames(input int unsigned w, input int unsigned h, input int frames,
                              input bit with_hold);
      int unsigned                cols, rows;
      bit                         smooth;
      logic [rsh_pkg::CHAN_W-1:0] base_r, base_g, base_b;
      cols = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
      rows = (h == 0) ? 1 : h;
      write_frame_size(w, h);
      if (with_hold) hold_request = 1'b1;
      repeat (frames) begin
         smooth = 1'($urandom_range(0, 1));
         base_r = rsh_pkg::CHAN_W'($urandom_range(0, 230));
         base_g = rsh_pkg::CHAN_W'($urandom_range(0, 230));
         base_b = rsh_pkg::CHAN_W'($urandom_range(0, 230));
         repeat (cols * rows)
            drive_pixel('{red_in: pick_level(smooth, base_r),
                          green_in: pick_level(smooth, base_g),
                          blue_in: pick_level(smooth, base_b)});
      end
   endtask

   initial begin
      int unsigned      w, h, pick, mode;
      int               random_start;
      rsh_pkg::req_type corner, side, mid;
      bit               hold_done, wide_done;
      hold_done = 1'b0;
      wide_done = 1'b0;
      do @(posedge clock); while (reset);

      // Zero width and height both count as one, so every request is a whole frame.
      write_frame_size(0, 0);
      drive_pixel(rgb(0, 0, 0));
      drive_pixel(rgb(255, 255, 255));
      drive_pixel(rgb(255, 0, 0));

      // The single interior pixel clamps high on red and low on green; blue stays in range.
      corner = rgb(128, 64, 32);
      side = rgb(0, 255, 10);
      mid = rgb(255, 0, 50);
      write_frame_size(3, 3);
      drive_pixel(corner);
      drive_pixel(side);
      drive_pixel(corner);
      drive_pixel(side);
      drive_pixel(mid);
      drive_pixel(side);
      drive_pixel(corner);
      drive_pixel(side);
      drive_pixel(corner);

      // Shrink the width in the middle of a row, then the height below the current row.
      write_frame_size(4, 65535);
      repeat (6) drive_pixel(rgb($urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 255)));
      write_frame_size(2, 65535);
      repeat (2) drive_pixel(rgb($urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 255)));
      write_frame_size(2, 2);
      repeat (4) drive_pixel(rgb($urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 255)));

      random_start = pixels_sent;
      while (pixels_sent - random_start < RANDOM_PIXELS) begin
         mode = (pixels_sent - random_start) * 3 / RANDOM_PIXELS;
         tx_idle_pct = (mode == 0) ? 25 : (mode == 1) ? 70 : 0;
         rx_idle_pct <= (mode == 0) ? 70 : (mode == 1) ? 25 : 0;
         if (mode == 2 && !hold_done) begin
            hold_done = 1'b1;
            send_frames(8, 6, 1, 1'b1);
         end else if (mode == 2 && !wide_done) begin
            // A part of an over-wide single row; every later width is narrower than
            // the columns sent, so the next frame starts again at its first pixel.
            wide_done = 1'b1;
            write_frame_size(4095, 1);
            repeat (WIDE_PIXELS) drive_pixel(rgb($urandom_range(0, 255),
                                                 $urandom_range(0, 255),
                                                 $urandom_range(0, 255)));
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 7) w = $urandom_range(1, 12);
            else if (pick < 9) w = $urandom_range(13, 40);
            else w = $urandom_range(0, 2);
            h = (w > 12) ? $urandom_range(1, 5) : $urandom_range(0, 9);
            send_frames(w, h, $urandom_range(1, 3), 1'b0);
         end
      end

      quiesce();
      $display("Sent %0d pixel requests under %0d frame sizes and compared %0d results.",
               pixels_sent, settings_used, checked_count);
      $display("Idle mixes: sender heavy, receiver heavy, none, and one long output hold-off.");
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/rsh_pkg.sv
hw/rtl/rsh_ram.sv
hw/rtl/rsh_front.sv
hw/rtl/rsh_fifo.sv
hw/rtl/rsh_back.sv
hw/rtl/rgb_sharpen_with_luma_histogram_unit.sv
hw/rtl/rsh_checker.sv
bench/rgb_sharpen_checker.sv
bench/rgb_sharpen_with_luma_histogram_unit_tb.sv
